// ===== rtl/quadrature_amplitude_detector_defines.svh =====
// Assertion macros for the quadrature amplitude detector.
// Used by rtl/quadrature_amplitude_detector.sv; expects clk_i and rst_ni in scope.
`ifndef QUADRATURE_AMPLITUDE_DETECTOR_DEFINES_SVH
`define QUADRATURE_AMPLITUDE_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define QAD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("quadrature_amplitude_detector: check failed");
// Next-cycle implication, disabled while reset is asserted.
`define QAD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("quadrature_amplitude_detector: check failed");
`else
`define QAD_ASSERT_IMP(lbl, ante, cons)
`define QAD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/qad_pkg.sv =====
// Package for the quadrature amplitude detector: constants and the sequencer state type.
// No dependencies.
package qad_pkg;

  // Default converter sample width.
  localparam int SAMPLE_BITS_DEF = 10;

  // Duty scaling and saturation.
  localparam int DUTY_W        = 7;
  localparam int DUTY_MAX      = 64;
  localparam int DUTY_SHIFT_UP = 6;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_SQRT,
    ST_ROUND
  } qad_state_e;

endpackage

// ===== rtl/quadrature_amplitude_detector.sv =====
// Quadrature amplitude detector: sample-pair difference, bit-serial square and square root.
// Depends on qad_pkg and quadrature_amplitude_detector_defines.svh.
// A request is accepted only in the idle state; no new request is taken until the current one
// has passed through the squarer, sum, square root, round and idle states in that order;
// a stalled duty holds the round state.
// Reset (asynchronous, active low) clears the sample ring, ring index, square terms,
// the sequencer and the output valid.
`include "quadrature_amplitude_detector_defines.svh"

module quadrature_amplitude_detector import qad_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [DUTY_W-1:0]      duty_o
);

  localparam int RootW       = SAMPLE_BITS + 1;
  localparam int RadW        = 2 * RootW;
  localparam int SqW         = 2 * SAMPLE_BITS;
  localparam int SumW        = SqW + 1;
  localparam int CntW        = $clog2(RootW + 1);
  localparam int DutyShiftDn = SAMPLE_BITS - DUTY_SHIFT_UP;

  // State and registers.
  qad_state_e             state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [SAMPLE_BITS-1:0] ring_q [4];
  logic [1:0]             ring_index_q;
  logic                   par_q;
  logic [SAMPLE_BITS-1:0] diff_q;
  logic [SqW-1:0]         prod_q;
  logic [SqW-1:0]         term_q [2];
  logic [RadW-1:0]        rad_q;
  logic [RootW:0]         rem_q;
  logic [RootW-1:0]       root_q;
  logic                   out_valid_q;
  logic [DUTY_W-1:0]      duty_q;

  // Control from the output decoder.
  logic in_accept;
  logic out_free;
  logic out_load;

  // Difference against the other entry of the same pair.
  logic [SAMPLE_BITS-1:0] partner;
  logic [SAMPLE_BITS-1:0] diff;

  assign partner = ring_q[ring_index_q ^ 2'b10];
  assign diff    = (sample_i >= partner) ? (sample_i - partner) : (partner - sample_i);

  // Shift-add squarer step: high half accumulates, product shifts right.
  logic [SAMPLE_BITS:0] mul_sum;

  assign mul_sum = {1'b0, prod_q[SqW-1:SAMPLE_BITS]}
                 + {1'b0, (prod_q[0] ? diff_q : '0)};

  // Sum of both square terms with the fresh one replacing its slot.
  logic [SumW-1:0] n_sum;

  assign n_sum = par_q ? ({1'b0, term_q[0]} + {1'b0, prod_q})
                       : ({1'b0, prod_q} + {1'b0, term_q[1]});

  // Restoring square root step, one root bit per cycle.
  logic [RootW+2:0] sq_cand;
  logic [RootW+2:0] sq_trial;
  logic             sq_ge;
  logic [RootW+2:0] sq_diff;

  assign sq_cand  = {rem_q, rad_q[RadW-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_cand >= sq_trial;
  assign sq_diff  = sq_cand - sq_trial;

  // Round to nearest, scale and saturate.
  logic             rnd_up;
  logic [RootW:0]   rounded;
  logic [RootW:0]   scaled;
  logic [DUTY_W-1:0] duty_d;

  assign rnd_up  = rem_q > {1'b0, root_q};
  assign rounded = {1'b0, root_q} + {{RootW{1'b0}}, rnd_up};
  assign scaled  = rounded >> DutyShiftDn;
  assign duty_d  = (scaled > (RootW + 1)'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX)
                                                    : scaled[DUTY_W-1:0];

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL;
          cnt_d   = '0;
        end
      end
      ST_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(SAMPLE_BITS - 1)) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        state_d = ST_SQRT;
        cnt_d   = '0;
      end
      ST_SQRT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(RootW - 1)) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output decoding.
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_ROUND: out_load   = out_free;
      default: begin
        in_stall_o = 1'b1;
        out_load   = 1'b0;
      end
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Control and model state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      ring_index_q <= '0;
      out_valid_q  <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        ring_q[k] <= '0;
      end
      term_q[0] <= '0;
      term_q[1] <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (in_accept) begin
        ring_q[ring_index_q] <= sample_i;
        ring_index_q         <= ring_index_q + 2'd1;
      end
      if (state_q == ST_SUM) begin
        term_q[par_q] <= prod_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      par_q  <= ring_index_q[0];
      diff_q <= diff;
      prod_q <= {{SAMPLE_BITS{1'b0}}, diff};
    end else if (state_q == ST_MUL) begin
      prod_q <= {mul_sum, prod_q[SAMPLE_BITS-1:1]};
    end
    if (state_q == ST_SUM) begin
      rad_q  <= RadW'(n_sum);
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == ST_SQRT) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= sq_ge ? sq_diff[RootW:0] : sq_cand[RootW:0];
      root_q <= {root_q[RootW-2:0], sq_ge};
    end
    if (out_load) begin
      duty_q <= duty_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;

  // Checks.
  `QAD_ASSERT_NXT(a_accept_starts_mul, in_accept, (state_q == ST_MUL) && (cnt_q == '0))
  `QAD_ASSERT_NXT(a_index_advances, in_accept, ring_index_q == ($past(ring_index_q) + 2'd1))
  `QAD_ASSERT_NXT(a_mul_to_sum, (state_q == ST_MUL) && (cnt_q == CntW'(SAMPLE_BITS - 1)),
                  state_q == ST_SUM)
  `QAD_ASSERT_NXT(a_round_holds, (state_q == ST_ROUND) && out_valid_q && out_stall_i,
                  state_q == ST_ROUND)
  `QAD_ASSERT_IMP(a_duty_range, out_valid_o, duty_o <= DUTY_W'(DUTY_MAX))

endmodule
